FILE: sv/b2da_pkg.sv
// Shared types, constants and digit extraction for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int unsigned NUM_DIGITS = 5;
	localparam int unsigned POS_W      = 3;

	localparam logic [13:0] W_TEN_THOUSAND = 14'd10000;
	localparam logic [13:0] W_THOUSAND     = 14'd1000;
	localparam logic [13:0] W_HUNDRED      = 14'd100;
	localparam logic [13:0] W_TEN          = 14'd10;

	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

	typedef struct packed {
		logic [3:0]  digit;
		logic [15:0] rem;
	} dgt_t;

	// Split off one decimal digit of weight w from r (r < 10*w assumed).
	function automatic dgt_t dec_digit(input logic [15:0] r, input logic [13:0] w);
		dgt_t        res;
		logic [16:0] mult;
		res.digit = 4'd0;
		res.rem   = r;
		for (int k = 1; k <= 9; k++) begin
			mult = 17'(k) * {3'b000, w};
			if ({1'b0, r} >= mult) begin
				res.digit = 4'(k);
				res.rem   = 16'({1'b0, r} - mult);
			end
		end
		return res;
	endfunction

endpackage

FILE: sv/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: four digit stages followed by a digit emitter.
// An item passes stages 1 to 4 and loads into the emitter; its digits then strobe out one a cycle.
// New items enter while earlier ones emit; the single result port sets the pace, 1 to 5 digits per item.
// The stages advance with valid bits; busy rises only while stage 1 is held by a full pipe.
// The receiver cannot stall; digits leave the emitter at one per cycle without backpressure.
// Reset clears all valid bits and the output strobe; payload registers are not reset.
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	output logic        strobe,
	output logic [5:0]  digit_char,
	output logic        last_digit
);

	// Pipeline registers
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0]  d4_s1;
	logic [13:0] rem_s1;
	logic [2:0]  d4_s2;
	logic [3:0]  d3_s2;
	logic [9:0]  rem_s2;
	logic [2:0]  d4_s3;
	logic [3:0]  d3_s3, d2_s3;
	logic [6:0]  rem_s3;
	logic [2:0]  d4_s4;
	logic [3:0]  d3_s4, d2_s4, d1_s4, d0_s4;

	// Emitter and output registers
	logic                           em_valid_q;
	logic [b2da_pkg::POS_W-1:0]     em_pos_q;
	logic [3:0]                     em_dig_q [b2da_pkg::NUM_DIGITS];
	logic                           strobe_q;
	logic [5:0]                     digit_char_q;
	logic                           last_digit_q;

	logic em_take, free4, free3, free2, accept;
	logic [b2da_pkg::POS_W-1:0] first_pos;
	b2da_pkg::dgt_t dg1, dg2, dg3, dg4;

	// Flow control: a stage loads when it is empty or its item moves on
	assign em_take = !em_valid_q || (em_pos_q == b2da_pkg::POS_LAST);
	assign free4   = !valid_s4 || em_take;
	assign free3   = !valid_s3 || free4;
	assign free2   = !valid_s2 || free3;
	assign busy    = valid_s1 && !free2;
	assign accept  = start && !busy;

	// Digit extraction per stage
	assign dg1 = b2da_pkg::dec_digit(value, b2da_pkg::W_TEN_THOUSAND);
	assign dg2 = b2da_pkg::dec_digit({2'b00, rem_s1}, b2da_pkg::W_THOUSAND);
	assign dg3 = b2da_pkg::dec_digit({6'b0, rem_s2}, b2da_pkg::W_HUNDRED);
	assign dg4 = b2da_pkg::dec_digit({9'b0, rem_s3}, b2da_pkg::W_TEN);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (!busy) valid_s1 <= start;
			if (free2) valid_s2 <= valid_s1;
			if (free3) valid_s3 <= valid_s2;
			if (free4) valid_s4 <= valid_s3;
		end
	end

	// Payload stages: hold while the next stage is full
	always_ff @(posedge clk) begin
		if (accept) begin
			d4_s1  <= dg1.digit[2:0];
			rem_s1 <= dg1.rem[13:0];
		end
		if (free2) begin
			d4_s2  <= d4_s1;
			d3_s2  <= dg2.digit;
			rem_s2 <= dg2.rem[9:0];
		end
		if (free3) begin
			d4_s3  <= d4_s2;
			d3_s3  <= d3_s2;
			d2_s3  <= dg3.digit;
			rem_s3 <= dg3.rem[6:0];
		end
		if (free4) begin
			d4_s4 <= d4_s3;
			d3_s4 <= d3_s3;
			d2_s4 <= d2_s3;
			d1_s4 <= dg4.digit;
			d0_s4 <= dg4.rem[3:0];
		end
	end

	// Find the leading nonzero digit; zero drops to the ones place
	always_comb begin
		if (d4_s4 != 3'd0)      first_pos = b2da_pkg::POS_W'(0);
		else if (d3_s4 != 4'd0) first_pos = b2da_pkg::POS_W'(1);
		else if (d2_s4 != 4'd0) first_pos = b2da_pkg::POS_W'(2);
		else if (d1_s4 != 4'd0) first_pos = b2da_pkg::POS_W'(3);
		else                    first_pos = b2da_pkg::POS_LAST;
	end

	// Emitter control: advance one digit a cycle, reload after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_pos_q   <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= em_valid_q;
			if (em_take) begin
				em_valid_q <= valid_s4;
				em_pos_q   <= first_pos;
			end else begin
				em_pos_q <= em_pos_q + 1'b1;
			end
		end
	end

	// Emitter digits and output payload
	always_ff @(posedge clk) begin
		if (em_take && valid_s4) begin
			em_dig_q[0] <= {1'b0, d4_s4};
			em_dig_q[1] <= d3_s4;
			em_dig_q[2] <= d2_s4;
			em_dig_q[3] <= d1_s4;
			em_dig_q[4] <= d0_s4;
		end
		digit_char_q <= b2da_pkg::ASCII_ZERO | {2'b00, em_dig_q[em_pos_q]};
		last_digit_q <= (em_pos_q == b2da_pkg::POS_LAST);
	end

	assign strobe     = strobe_q;
	assign digit_char = digit_char_q;
	assign last_digit = last_digit_q;

endmodule
